[rtl/core/emoji_font_run_segmenter_defines.svh]
// Assertion helpers used by the segmenter's run queue.
`ifndef EMOJI_FONT_RUN_SEGMENTER_DEFINES_SVH
`define EMOJI_FONT_RUN_SEGMENTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EFRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EFRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/efrs_pkg.sv]
package efrs_pkg;

  localparam int unsigned MAX_TEXT_BYTES = 65536;
  localparam int unsigned POS_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_BYTES);
  localparam logic [POS_W-1:0] START_MAX = POS_W'(MAX_TEXT_BYTES - 1);
  localparam int unsigned CP_W = 21;
  localparam int unsigned MAX_RUNS = 4;

  // Codepoint kinds.
  localparam logic [3:0] K_PLAIN    = 4'd0;
  localparam logic [3:0] K_EMO      = 4'd1;
  localparam logic [3:0] K_EMOTXT   = 4'd2;
  localparam logic [3:0] K_ZWJ      = 4'd3;
  localparam logic [3:0] K_RI       = 4'd4;
  localparam logic [3:0] K_KEYCAP   = 4'd5;
  localparam logic [3:0] K_TONE     = 4'd6;
  localparam logic [3:0] K_VS16     = 4'd7;
  localparam logic [3:0] K_VS15     = 4'd8;
  localparam logic [3:0] K_FLAGBASE = 4'd9;
  localparam logic [3:0] K_TAG      = 4'd10;
  localparam logic [3:0] K_TAGEND   = 4'd11;

  localparam logic [CP_W-1:0] CP_ZWJ     = 21'h0200D;
  localparam logic [CP_W-1:0] CP_VS16    = 21'h0FE0F;
  localparam logic [CP_W-1:0] CP_VS15    = 21'h0FE0E;
  localparam logic [CP_W-1:0] CP_KEYCAP  = 21'h020E3;
  localparam logic [CP_W-1:0] CP_FLAG    = 21'h1F3F4;
  localparam logic [CP_W-1:0] CP_RI_LO   = 21'h1F1E6;
  localparam logic [CP_W-1:0] CP_RI_HI   = 21'h1F1FF;
  localparam logic [CP_W-1:0] CP_TONE_LO = 21'h1F3FB;
  localparam logic [CP_W-1:0] CP_TONE_HI = 21'h1F3FF;
  localparam logic [CP_W-1:0] CP_TAGEND  = 21'hE007F;
  localparam logic [CP_W-1:0] CP_TAG_LO  = 21'hE0020;
  localparam logic [CP_W-1:0] CP_TAG_HI  = 21'hE007E;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } span_t;

  localparam int unsigned N_EMO = 9;
  localparam int unsigned N_TXT = 30;

  localparam span_t EMO_SPANS [N_EMO] = '{
    '{21'h1F300, 21'h1F5FF}, '{21'h1F600, 21'h1F64F}, '{21'h1F680, 21'h1F6FF},
    '{21'h1F7E0, 21'h1F7EB}, '{21'h1F7F0, 21'h1F7F0}, '{21'h1F900, 21'h1F9FF},
    '{21'h1FA70, 21'h1FAFF}, '{21'h02600, 21'h026FF}, '{21'h02700, 21'h027BF}
  };

  localparam span_t TXT_SPANS [N_TXT] = '{
    '{21'h00023, 21'h00023}, '{21'h0002A, 21'h0002A}, '{21'h00030, 21'h00039},
    '{21'h000A9, 21'h000A9}, '{21'h000AE, 21'h000AE}, '{21'h0203C, 21'h0203C},
    '{21'h02049, 21'h02049}, '{21'h02122, 21'h02122}, '{21'h02139, 21'h02139},
    '{21'h02194, 21'h02199}, '{21'h021A9, 21'h021AA}, '{21'h0231A, 21'h0231B},
    '{21'h02328, 21'h02328}, '{21'h023CF, 21'h023CF}, '{21'h023E9, 21'h023F3},
    '{21'h023F8, 21'h023FA}, '{21'h024C2, 21'h024C2}, '{21'h025AA, 21'h025AB},
    '{21'h025B6, 21'h025B6}, '{21'h025C0, 21'h025C0}, '{21'h025FB, 21'h025FE},
    '{21'h02934, 21'h02935}, '{21'h02B05, 21'h02B07}, '{21'h02B1B, 21'h02B1C},
    '{21'h02B50, 21'h02B50}, '{21'h02B55, 21'h02B55}, '{21'h03030, 21'h03030},
    '{21'h0303D, 21'h0303D}, '{21'h03297, 21'h03297}, '{21'h03299, 21'h03299}
  };

  typedef struct packed {
    logic [15:0]      start;
    logic [POS_W-1:0] stop;
    logic             emoji;
    logic             last;
  } run_t;

  typedef struct packed {
    logic [3:0]       prev_kind;
    logic [POS_W-1:0] cl_start;
    logic [3:0]       cl_first;
    logic             emo;
    logic             txt;
    logic             cl_open;
    logic             cl_single;
    logic [POS_W-1:0] run_begin;
    logic             run_role;
    logic             run_open;
  } seg_t;

  typedef struct packed {
    seg_t st;
    logic ev;
    run_t run;
  } feed_t;

  localparam seg_t SEG_RESET = '{
    prev_kind: K_PLAIN, cl_start: '0, cl_first: K_PLAIN, emo: 1'b0, txt: 1'b0,
    cl_open: 1'b0, cl_single: 1'b0, run_begin: '0, run_role: 1'b0, run_open: 1'b0
  };

  function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] a, logic [1:0] n);
    logic [POS_W:0] s;
    s = {1'b0, a} + (POS_W+1)'(n);
    return (s > {1'b0, POS_MAX}) ? POS_MAX : s[POS_W-1:0];
  endfunction

  function automatic logic [2:0] seq_len(logic [7:0] b);
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    return 3'd1;
  endfunction

  function automatic logic [3:0] kind_of(logic [CP_W-1:0] cp);
    logic emo_hit;
    logic txt_hit;
    emo_hit = 1'b0;
    txt_hit = 1'b0;
    for (int i = 0; i < N_EMO; i++) begin
      if (cp >= EMO_SPANS[i].lo && cp <= EMO_SPANS[i].hi) emo_hit = 1'b1;
    end
    for (int i = 0; i < N_TXT; i++) begin
      if (cp >= TXT_SPANS[i].lo && cp <= TXT_SPANS[i].hi) txt_hit = 1'b1;
    end
    if (cp == CP_ZWJ) return K_ZWJ;
    if (cp == CP_VS16) return K_VS16;
    if (cp == CP_VS15) return K_VS15;
    if (cp == CP_KEYCAP) return K_KEYCAP;
    if (cp == CP_FLAG) return K_FLAGBASE;
    if (cp >= CP_RI_LO && cp <= CP_RI_HI) return K_RI;
    if (cp >= CP_TONE_LO && cp <= CP_TONE_HI) return K_TONE;
    if (cp == CP_TAGEND) return K_TAGEND;
    if (cp >= CP_TAG_LO && cp <= CP_TAG_HI) return K_TAG;
    if (emo_hit) return K_EMO;
    if (txt_hit) return K_EMOTXT;
    return K_PLAIN;
  endfunction

  function automatic run_t make_run(logic [POS_W-1:0] s, logic [POS_W-1:0] e,
                                    logic role, logic last);
    run_t r;
    logic [POS_W-1:0] sc;
    sc = (s > START_MAX) ? START_MAX : s;
    r.start = sc[15:0];
    r.stop  = e;
    r.emoji = role;
    r.last  = last;
    return r;
  endfunction

  function automatic seg_t note_marks(seg_t s, logic [3:0] k);
    seg_t r;
    r = s;
    if (k inside {K_EMO, K_RI, K_TONE, K_KEYCAP, K_FLAGBASE, K_TAG, K_VS16}) r.emo = 1'b1;
    else if (k == K_VS15) r.txt = 1'b1;
    return r;
  endfunction

  function automatic logic joins(logic [3:0] prev, logic [3:0] cur, logic emo_so_far);
    if (cur == K_ZWJ) return emo_so_far;
    if (prev == K_ZWJ) return cur inside {K_EMO, K_EMOTXT, K_FLAGBASE};
    if (cur == K_VS16 || cur == K_VS15) return 1'b1;
    if (cur == K_TONE || cur == K_KEYCAP) return prev inside {K_EMO, K_EMOTXT, K_VS16};
    if (cur == K_TAG || cur == K_TAGEND) return emo_so_far;
    return 1'b0;
  endfunction

  // Close the open cluster; emit the previous run when the role flips.
  function automatic feed_t close_cluster(seg_t s);
    feed_t r;
    logic role;
    r.st  = s;
    r.ev  = 1'b0;
    r.run = '0;
    role  = 1'b0;
    if (s.cl_open) begin
      if (s.cl_first == K_RI) role = 1'b1;
      else if (s.txt) role = 1'b0;
      else if (s.emo && (s.cl_first inside {K_EMO, K_FLAGBASE, K_EMOTXT})) role = 1'b1;
      if (!s.run_open || s.run_role != role) begin
        if (s.run_open) begin
          r.ev  = 1'b1;
          r.run = make_run(s.run_begin, s.cl_start, s.run_role, 1'b0);
        end
        r.st.run_begin = s.cl_start;
        r.st.run_role  = role;
        r.st.run_open  = 1'b1;
      end
      r.st.cl_open = 1'b0;
    end
    return r;
  endfunction

  function automatic feed_t feed_cp(seg_t s, logic [CP_W-1:0] cp, logic [POS_W-1:0] at);
    feed_t r;
    logic [3:0] k;
    logic ext;
    r.st  = s;
    r.ev  = 1'b0;
    r.run = '0;
    ext   = 1'b0;
    k     = kind_of(cp);
    if (s.cl_open) begin
      if (s.cl_first == K_RI) ext = (k == K_RI) && s.cl_single;
      else ext = joins(s.prev_kind, k, s.emo && !s.txt);
      if (ext) begin
        r.st = note_marks(s, k);
        r.st.prev_kind = k;
        r.st.cl_single = 1'b0;
        return r;
      end
      r = close_cluster(s);
    end
    r.st.cl_open   = 1'b1;
    r.st.cl_single = 1'b1;
    r.st.cl_start  = at;
    r.st.cl_first  = k;
    r.st.prev_kind = k;
    r.st.emo       = 1'b0;
    r.st.txt       = 1'b0;
    r.st = note_marks(r.st, k);
    return r;
  endfunction

endpackage

[rtl/core/efrs_run_fifo.sv]
module efrs_run_fifo
  import efrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] push_n_i,
  input  run_t       push_data_i [MAX_RUNS],
  output logic       room_o,
  output logic       out_valid_o,
  output run_t       out_data_o,
  input  logic       out_ready_i
);

  localparam int unsigned DEPTH = 2 * MAX_RUNS;
  localparam int unsigned AW = $clog2(DEPTH);

  run_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign room_o      = (cnt_q <= (AW+1)'(DEPTH - MAX_RUNS));

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_RUNS; j++) begin
      if (3'(j) < push_n_i) mem_q[wr_q + AW'(j)] <= push_data_i[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + AW'(push_n_i);
      rd_q  <= rd_q + AW'(pop);
      cnt_q <= cnt_q + (AW+1)'(push_n_i) - (AW+1)'(pop);
    end
  end

`include "emoji_font_run_segmenter_defines.svh"

  `EFRS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (AW+1)'(DEPTH), "run queue overfilled")
  `EFRS_ASSERT_IMP(a_push_room, push_n_i != 3'd0, room_o, "runs pushed without room")
  `EFRS_ASSERT_NXT(a_cnt_track, 1'b1,
    cnt_q == $past(cnt_q) + (AW+1)'($past(push_n_i)) - (AW+1)'($past(pop)),
    "run queue count lost track")

endmodule

[rtl/core/emoji_font_run_segmenter.sv]
// A run is written into the run queue when the byte that closes it is accepted, and leaves on m_axis from there.
// One byte per cycle while the run queue has room; a byte may release up to four runs, drained one per beat.
// Input stalls only while the eight-entry run queue has fewer than four free slots.
// Reset (rst_ni low, asynchronous) empties the queue and returns the segmenter to offset 0.
// The last byte of a text also returns all segmenter state to its reset value.
module emoji_font_run_segmenter
  import efrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] run_start, [32:16] run_end, rest zero
  output logic        m_axis_tuser,   // emoji_run
  output logic        m_axis_tlast    // last_run
);

  // Decode state: bytes of an unfinished UTF-8 sequence, lead byte first.
  logic [7:0]       pend_q [3];
  logic [7:0]       pend_d [3];
  logic [1:0]       pc_q, pc_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] cps_q, cps_d;
  seg_t             st_q, st_d;

  logic             accept;
  logic             room;
  logic [2:0]       push_n;
  run_t             push_data [MAX_RUNS];
  run_t             out_run;

  // Six possible run events per byte: three raw flushes, one main codepoint,
  // the closing cluster on the last byte and the final run. Keep the first four.
  logic             ev   [6];
  run_t             evr  [6];

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    logic [7:0]       b;
    logic             last, cont, fresh, flush_en, main_en;
    logic [2:0]       need;
    logic [CP_W-1:0]  main_cp;
    logic [POS_W-1:0] main_at, npos;
    seg_t             s;
    feed_t            f;
    logic [2:0]       cnt;

    b        = s_axis_tdata;
    last     = s_axis_tlast;
    cont     = (b[7:6] == 2'b10);
    fresh    = 1'b1;
    flush_en = 1'b0;
    main_en  = 1'b0;
    main_cp  = CP_W'(b);
    main_at  = pos_q;
    need     = seq_len(pend_q[0]);
    npos     = sat_add(pos_q, 2'd1);
    pend_d   = pend_q;
    pc_d     = pc_q;
    cps_d    = cps_q;
    s        = st_q;
    f        = '0;
    for (int i = 0; i < 6; i++) begin
      ev[i]  = 1'b0;
      evr[i] = '0;
    end

    if (pc_q != 2'd0) begin
      if (cont) begin
        fresh = 1'b0;
        if (3'(pc_q) + 3'd1 == need) begin
          // Complete sequence: assemble the codepoint at its lead offset.
          case (need)
            3'd2:    main_cp = {10'd0, pend_q[0][4:0], b[5:0]};
            3'd3:    main_cp = {5'd0, pend_q[0][3:0], pend_q[1][5:0], b[5:0]};
            default: main_cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], b[5:0]};
          endcase
          main_at = cps_q;
          main_en = 1'b1;
          pc_d    = 2'd0;
        end else if (last || pc_q == 2'd3) begin
          flush_en = 1'b1;
          main_en  = 1'b1;
          pc_d     = 2'd0;
        end else begin
          pend_d[pc_q] = b;
          pc_d         = pc_q + 2'd1;
        end
      end else begin
        flush_en = 1'b1;
        pc_d     = 2'd0;
      end
    end

    if (fresh) begin
      if (seq_len(b) == 3'd1 || last) begin
        main_en = 1'b1;
      end else begin
        pend_d[0] = b;
        pc_d      = 2'd1;
        cps_d     = pos_q;
      end
    end

    // Drop pending bytes back in as raw one-byte codepoints.
    for (int i = 0; i < 3; i++) begin
      if (flush_en && 2'(i) < pc_q) begin
        f      = feed_cp(s, CP_W'(pend_q[i]), sat_add(cps_q, 2'(i)));
        s      = f.st;
        ev[i]  = f.ev;
        evr[i] = f.run;
      end
    end

    if (main_en) begin
      f      = feed_cp(s, main_cp, main_at);
      s      = f.st;
      ev[3]  = f.ev;
      evr[3] = f.run;
    end

    pos_d = npos;
    if (last) begin
      f      = close_cluster(s);
      s      = f.st;
      ev[4]  = f.ev;
      evr[4] = f.run;
      ev[5]  = s.run_open;
      evr[5] = make_run(s.run_begin, npos, s.run_role, 1'b1);
      s      = SEG_RESET;
      pc_d   = 2'd0;
      pos_d  = '0;
      cps_d  = '0;
    end
    st_d = s;

    // Pack events in order into the queue slots.
    cnt = 3'd0;
    for (int j = 0; j < MAX_RUNS; j++) push_data[j] = '0;
    for (int i = 0; i < 6; i++) begin
      if (ev[i] && cnt < 3'(MAX_RUNS)) begin
        push_data[cnt[1:0]] = evr[i];
        cnt = cnt + 3'd1;
      end
    end
    push_n = accept ? cnt : 3'd0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= 2'd0;
      pos_q <= '0;
      cps_q <= '0;
      st_q  <= SEG_RESET;
    end else if (accept) begin
      pc_q  <= pc_d;
      pos_q <= pos_d;
      cps_q <= cps_d;
      st_q  <= st_d;
    end
  end

  // Result queue doubles as the output register toward the consumer.
  efrs_run_fifo u_run_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_run),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, out_run.stop, out_run.start};
  assign m_axis_tuser = out_run.emoji;
  assign m_axis_tlast = out_run.last;

endmodule

[verif/emoji_font_run_segmenter_tb.sv]
module emoji_font_run_segmenter_tb;
  import efrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct {
    logic [15:0] start;
    logic [16:0] stop;
    logic        emoji;
    logic        last;
  } font_run_t;

  typedef struct {
    logic [7:0] bv;
    logic       last;
    logic       typed;
    font_run_t  run;
  } beat_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  emoji_font_run_segmenter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  font_run_t   expected_runs[$];
  font_run_t   step_runs[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          quiet;
  logic [7:0]  text_bytes[$];

  // Segmenter shadow state.
  logic [7:0]  pend[3];
  int unsigned pend_cnt;
  int unsigned byte_pos;
  int unsigned cp_start;
  logic [3:0]  prev_kind;
  int unsigned cl_start;
  logic [3:0]  cl_first;
  bit          emo_mark;
  bit          txt_mark;
  bit          cl_open;
  bit          cl_single;
  int unsigned run_begin;
  bit          run_role;
  bit          run_open;

  task automatic report(string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic int unsigned sat_pos(int unsigned a, int unsigned n);
    return (a + n > MAX_TEXT_BYTES) ? MAX_TEXT_BYTES : a + n;
  endfunction

  function automatic int unsigned utf8_len(logic [7:0] b);
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 1;
  endfunction

  function automatic logic [3:0] classify_cp(logic [20:0] cp);
    if (cp == CP_ZWJ) return K_ZWJ;
    if (cp == CP_VS16) return K_VS16;
    if (cp == CP_VS15) return K_VS15;
    if (cp == CP_KEYCAP) return K_KEYCAP;
    if (cp == CP_FLAG) return K_FLAGBASE;
    if (cp >= CP_RI_LO && cp <= CP_RI_HI) return K_RI;
    if (cp >= CP_TONE_LO && cp <= CP_TONE_HI) return K_TONE;
    if (cp == CP_TAGEND) return K_TAGEND;
    if (cp >= CP_TAG_LO && cp <= CP_TAG_HI) return K_TAG;
    foreach (EMO_SPANS[i])
      if (cp >= EMO_SPANS[i].lo && cp <= EMO_SPANS[i].hi) return K_EMO;
    foreach (TXT_SPANS[i])
      if (cp >= TXT_SPANS[i].lo && cp <= TXT_SPANS[i].hi) return K_EMOTXT;
    return K_PLAIN;
  endfunction

  function automatic void clear_segmenter();
    pend_cnt = 0; byte_pos = 0; cp_start = 0;
    prev_kind = K_PLAIN; cl_first = K_PLAIN; cl_start = 0;
    emo_mark = 0; txt_mark = 0; cl_open = 0; cl_single = 0;
    run_begin = 0; run_role = 0; run_open = 0;
  endfunction

  function automatic void queue_run(font_run_t r);
    expected_runs.insert(expected_runs.size(), r);
  endfunction

  function automatic void push_run(int unsigned s, int unsigned e, bit role, bit lst);
    font_run_t r;
    if (step_runs.size() >= MAX_RUNS) return;
    if (s > MAX_TEXT_BYTES - 1) s = MAX_TEXT_BYTES - 1;
    r.start = s[15:0];
    r.stop  = e[16:0];
    r.emoji = role;
    r.last  = lst;
    step_runs.insert(step_runs.size(), r);
  endfunction

  function automatic void mark_kind(logic [3:0] k);
    if (k inside {K_EMO, K_RI, K_TONE, K_KEYCAP, K_FLAGBASE, K_TAG, K_VS16}) emo_mark = 1;
    else if (k == K_VS15) txt_mark = 1;
  endfunction

  function automatic bit extends_cluster(logic [3:0] k);
    bit emo_so_far;
    emo_so_far = emo_mark && !txt_mark;
    if (cl_first == K_RI) return (k == K_RI) && cl_single;
    if (k == K_ZWJ) return emo_so_far;
    if (prev_kind == K_ZWJ) return k inside {K_EMO, K_EMOTXT, K_FLAGBASE};
    if (k == K_VS16 || k == K_VS15) return 1;
    if (k == K_TONE || k == K_KEYCAP) return prev_kind inside {K_EMO, K_EMOTXT, K_VS16};
    if (k == K_TAG || k == K_TAGEND) return emo_so_far;
    return 0;
  endfunction

  // Close the open cluster, flushing the run before it when the role flips.
  function automatic void close_cluster_pred();
    bit role;
    if (!cl_open) return;
    role = 0;
    if (cl_first == K_RI) role = 1;
    else if (txt_mark) role = 0;
    else if (emo_mark && cl_first inside {K_EMO, K_FLAGBASE, K_EMOTXT}) role = 1;
    if (!run_open || run_role != role) begin
      if (run_open) push_run(run_begin, cl_start, run_role, 0);
      run_begin = cl_start;
      run_role  = role;
      run_open  = 1;
    end
    cl_open = 0;
  endfunction

  function automatic void add_codepoint(logic [20:0] cp, int unsigned at);
    logic [3:0] k;
    k = classify_cp(cp);
    if (cl_open) begin
      if (extends_cluster(k)) begin
        mark_kind(k);
        prev_kind = k;
        cl_single = 0;
        return;
      end
      close_cluster_pred();
    end
    cl_open = 1; cl_single = 1; cl_start = at; cl_first = k; prev_kind = k;
    emo_mark = 0; txt_mark = 0;
    mark_kind(k);
  endfunction

  function automatic void flush_raw();
    for (int i = 0; i < pend_cnt && i < 3; i++)
      add_codepoint({13'd0, pend[i]}, sat_pos(cp_start, i));
    pend_cnt = 0;
  endfunction

  // Advance the shadow segmenter by one byte; runs land in step_runs.
  function automatic void segment_byte(logic [7:0] b, bit lst);
    int unsigned pos;
    int unsigned need;
    bit fresh;
    logic [20:0] cp;
    step_runs.delete();
    pos = byte_pos;
    byte_pos = sat_pos(pos, 1);
    fresh = 1;
    if (pend_cnt > 0) begin
      if (b[7:6] == 2'b10) begin
        need = utf8_len(pend[0]);
        fresh = 0;
        if (pend_cnt + 1 == need) begin
          cp = pend[0] & (need == 2 ? 8'h1F : need == 3 ? 8'h0F : 8'h07);
          for (int i = 1; i < pend_cnt && i < 3; i++) cp = (cp << 6) | pend[i][5:0];
          cp = (cp << 6) | b[5:0];
          pend_cnt = 0;
          add_codepoint(cp, cp_start);
        end else if (lst || pend_cnt >= 3) begin
          flush_raw();
          add_codepoint({13'd0, b}, pos);
        end else begin
          pend[pend_cnt] = b;
          pend_cnt++;
        end
      end else begin
        flush_raw();
      end
    end
    if (fresh) begin
      if (utf8_len(b) == 1 || lst) add_codepoint({13'd0, b}, pos);
      else begin
        pend[0] = b; pend_cnt = 1; cp_start = pos;
      end
    end
    if (lst) begin
      close_cluster_pred();
      if (run_open) push_run(run_begin, byte_pos, run_role, 1);
      clear_segmenter();
    end
  endfunction

  // Present one beat and hold it until accepted; the shadow model advances on acceptance.
  task automatic send_beat(logic [7:0] b, bit lst, bit typed, font_run_t run);
    if (!quiet && $urandom_range(99) < 39) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(negedge clk_i); while (!s_axis_tready);
    segment_byte(b, lst);
    if (typed) queue_run(run);
    else foreach (step_runs[i]) queue_run(step_runs[i]);
    @(posedge clk_i);
  endtask

  function automatic void encode_cp(logic [20:0] cp, bit broken);
    logic [7:0] enc[$];
    if (cp < 21'h80) enc = '{cp[7:0]};
    else if (cp < 21'h800) enc = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    else if (cp < 21'h10000)
      enc = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    else enc = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
                 {2'b10, cp[5:0]}};
    if (broken && enc.size() > 1) void'(enc.pop_back());
    foreach (enc[i]) text_bytes.insert(text_bytes.size(), enc[i]);
  endfunction

  function automatic logic [20:0] pick_cp();
    case ($urandom_range(15))
      0:  return 21'($urandom_range(8'h7F));
      1:  return 21'(21'h30 + $urandom_range(9));
      2:  return CP_ZWJ;
      3:  return CP_VS16;
      4:  return CP_VS15;
      5:  return CP_KEYCAP;
      6:  return CP_FLAG;
      7:  return 21'(CP_RI_LO + $urandom_range(25));
      8:  return 21'(CP_TONE_LO + $urandom_range(4));
      9:  return ($urandom_range(3) == 0) ? CP_TAGEND : 21'(CP_TAG_LO + $urandom_range(94));
      10: return 21'(21'h1F600 + $urandom_range(8'h4F));
      11: return 21'(21'h2600 + $urandom_range(12'h1BF));
      12: return ($urandom_range(1)) ? 21'hA9 : 21'(21'h2194 + $urandom_range(5));
      13: return 21'(21'h1F300 + $urandom_range(16'h7FF));
      14: return 21'($urandom_range(21'h1FFFFF));
      default: return 21'h1F7F0;
    endcase
  endfunction

  beat_row_t directed[$];

  function automatic void add_row(beat_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  function automatic beat_row_t row(logic [7:0] b, bit lst);
    beat_row_t r;
    r.bv = b; r.last = lst; r.typed = 0; r.run = '{default: '0};
    return r;
  endfunction

  function automatic beat_row_t row_exp(logic [7:0] b, logic [15:0] s, logic [16:0] e,
                                        logic role);
    beat_row_t r;
    r = row(b, 1);
    r.typed = 1;
    r.run = '{start: s, stop: e, emoji: role, last: 1'b1};
    return r;
  endfunction

  // Output side: random backpressure and in-order comparison.
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= quiet || ($urandom_range(99) >= 28);
  end

  always @(negedge clk_i) begin
    font_run_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected run %h", m_axis_tdata));
      end else begin
        want = expected_runs.pop_front();
        if (m_axis_tdata[15:0] !== want.start)
          report($sformatf("run_start %0d, want %0d", m_axis_tdata[15:0], want.start));
        if (m_axis_tdata[32:16] !== want.stop)
          report($sformatf("run_end %0d, want %0d", m_axis_tdata[32:16], want.stop));
        if (m_axis_tdata[39:33] !== 7'd0) report("tdata pad bits not zero");
        if (m_axis_tuser !== want.emoji)
          report($sformatf("emoji_run %b, want %b", m_axis_tuser, want.emoji));
        if (m_axis_tlast !== want.last)
          report($sformatf("last_run %b, want %b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    font_run_t   none;
    int unsigned sent;
    logic [7:0]  keycap_seq [7];
    logic [7:0]  heart_seq [5];
    none = '{default: '0};
    keycap_seq = '{8'h31, 8'hEF, 8'hB8, 8'h8F, 8'hE2, 8'h83, 8'hA3};
    heart_seq = '{8'hE2, 8'h9D, 8'hA4, 8'hEF, 8'hB8};
    error_count = 0;
    cycle_count = 0;
    quiet = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    clear_segmenter();

    // Single ASCII byte, then a high raw byte, then a full emoji, then a stray continuation.
    add_row(row_exp(8'h41, 16'd0, 17'd1, 1'b0));
    add_row(row_exp(8'hFF, 16'd0, 17'd1, 1'b0));
    add_row(row(8'hF0, 0));
    add_row(row(8'h9F, 0));
    add_row(row(8'h98, 0));
    add_row(row_exp(8'h80, 16'd0, 17'd4, 1'b1));
    add_row(row_exp(8'h80, 16'd0, 17'd1, 1'b0));
    // Malformed two-byte lead followed by ASCII.
    add_row(row(8'hC3, 0));
    add_row(row(8'h41, 1));
    // Truncated three-byte sequence at the end of text.
    add_row(row(8'hE2, 0));
    add_row(row(8'h82, 1));
    // Keycap: '1' FE0F 20E3, then plain text.
    foreach (keycap_seq[i]) add_row(row(keycap_seq[i], 0));
    add_row(row(8'h78, 1));
    // Heart forced to text by FE0E.
    foreach (heart_seq[i]) add_row(row(heart_seq[i], 0));
    add_row(row(8'h8E, 1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_beat(directed[i].bv, directed[i].last, directed[i].typed,
                                    directed[i].run);

    // Random texts: mostly well-formed codepoint sequences, some noise and cut sequences.
    sent = 0;
    while (sent < 255) begin
      text_bytes.delete();
      repeat ($urandom_range(8, 1)) begin
        if ($urandom_range(99) < 12)
          text_bytes.insert(text_bytes.size(), 8'($urandom_range(255)));
        else encode_cp(pick_cp(), $urandom_range(99) < 8);
      end
      quiet = (sent >= 100 && sent < 160);
      foreach (text_bytes[i]) begin
        send_beat(text_bytes[i], i == text_bytes.size() - 1, 0, none);
        sent++;
      end
    end
    quiet = 0;

    s_axis_tvalid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[emoji_font_run_segmenter.f]
+incdir+rtl/core
rtl/core/efrs_pkg.sv
rtl/core/efrs_run_fifo.sv
rtl/core/emoji_font_run_segmenter.sv
verif/emoji_font_run_segmenter_tb.sv
